/* rtl/core/slc_pkg.sv */
// Shared types and constants of the source line classifier.
package slc_pkg;

  // Fixed field widths.
  localparam int BYTE_W      = 8;
  localparam int MARKER_BYTES = 7;
  localparam int MARKER_W    = MARKER_BYTES * BYTE_W;
  localparam int MLEN_W      = 3;
  localparam int OUT_W       = 32;

  // Configuration port.
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = MARKER_W;

  localparam logic [CFG_INDEX_W-1:0] REG_LINE_MARKER     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_LINE_MARKER_LEN = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_OPEN_MARKER     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_OPEN_MARKER_LEN = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_CLOSE_MARKER    = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_CLOSE_MARKER_LEN = 3'd5;

  // Parameter defaults.
  localparam int MAX_MARKER_BYTES_DEF = 7;
  localparam int COUNT_WIDTH_DEF      = 32;
  localparam int JOB_QUEUE_DEPTH_DEF  = 4;

  // Characters that steer line classification.
  localparam logic [BYTE_W-1:0] CHR_NL  = 8'h0A;
  localparam logic [BYTE_W-1:0] CHR_SP  = 8'h20;
  localparam logic [BYTE_W-1:0] CHR_TAB = 8'h09;

  // Marker configuration handed to the classifier.
  typedef struct packed {
    logic [MARKER_W-1:0] line_marker;
    logic [MLEN_W-1:0]   line_len;
    logic [MARKER_W-1:0] open_marker;
    logic [MLEN_W-1:0]   open_len;
    logic [MARKER_W-1:0] close_marker;
    logic [MLEN_W-1:0]   close_len;
  } cfg_t;

endpackage

/* rtl/core/slc_fifo.sv */
// Small job queue between the byte window and the line classifier.
module slc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = slc_pkg::JOB_QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PW = $clog2(DEPTH);
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr_r;
  logic [PW-1:0]    rd_ptr_r;
  logic [NW-1:0]    count_r;
  logic             do_push;
  logic             do_pop;

  assign full     = (count_r == NW'(DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push & ~full;
  assign do_pop   = pop & ~empty;
  assign pop_data = mem[rd_ptr_r];

  // Storage is written on every transfer in.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  // Pointers wrap at the queue depth.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

/* rtl/core/slc_front.sv */
// Input side: byte counter and lookahead window that issues classify jobs.
module slc_front #(
  parameter int MAX_MARKER_BYTES = slc_pkg::MAX_MARKER_BYTES_DEF,
  parameter int COUNT_WIDTH      = slc_pkg::COUNT_WIDTH_DEF,
  parameter int AVW              = $clog2(MAX_MARKER_BYTES + 1)
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_push,
  output logic                                 in_full,
  input  logic [slc_pkg::BYTE_W-1:0]           in_data_byte,
  input  logic                                 in_byte_present,
  input  logic                                 in_end_of_file,
  output logic                                 job_push,
  input  logic                                 job_full,
  output logic [MAX_MARKER_BYTES*slc_pkg::BYTE_W-1:0] job_window,
  output logic [AVW-1:0]                       job_avail,
  output logic                                 job_finish,
  output logic [COUNT_WIDTH-1:0]               job_bytes,
  output logic                                 job_bsat
);

  localparam int BW = slc_pkg::BYTE_W;

  logic [BW-1:0]          win_r [MAX_MARKER_BYTES];
  logic [AVW-1:0]         fill_r;
  logic                   flush_r;
  logic [COUNT_WIDTH-1:0] bytes_r;
  logic                   bsat_r;
  logic                   accept;
  logic                   win_full;
  logic                   full_push;
  logic                   flush_go;
  logic [COUNT_WIDTH-1:0] bytes_inc;

  assign in_full   = flush_r | job_full;
  assign accept    = in_push & ~in_full;
  assign win_full  = (fill_r == AVW'(MAX_MARKER_BYTES));
  assign full_push = accept & in_byte_present & win_full;
  assign flush_go  = flush_r & ~job_full;
  assign bytes_inc = (bytes_r != '1) ? bytes_r + 1'b1 : bytes_r;

  // A job leaves when the window head is pushed out or drained at the end.
  always_comb begin
    for (int i = 0; i < MAX_MARKER_BYTES; i++) begin
      job_window[i*BW +: BW] = win_r[i];
    end
    job_push   = full_push | flush_go;
    job_avail  = fill_r;
    job_finish = flush_r & (fill_r == '0);
    job_bytes  = bytes_r;
    job_bsat   = bsat_r;
  end

  // Window storage: append, shift on push-out, shift on drain.
  always_ff @(posedge clk) begin
    if (full_push || (flush_go && fill_r != '0)) begin
      for (int i = 0; i < MAX_MARKER_BYTES - 1; i++) begin
        win_r[i] <= win_r[i+1];
      end
    end
    if (full_push) begin
      win_r[MAX_MARKER_BYTES-1] <= in_data_byte;
    end else if (accept && in_byte_present) begin
      for (int i = 0; i < MAX_MARKER_BYTES; i++) begin
        if (AVW'(i) == fill_r) begin
          win_r[i] <= in_data_byte;
        end
      end
    end
  end

  // Fill level, byte count and end-of-file drain control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r  <= '0;
      flush_r <= 1'b0;
      bytes_r <= '0;
      bsat_r  <= 1'b0;
    end else if (flush_go) begin
      if (fill_r != '0) begin
        fill_r <= fill_r - 1'b1;
      end else begin
        flush_r <= 1'b0;
        bytes_r <= '0;
        bsat_r  <= 1'b0;
      end
    end else if (accept) begin
      if (in_byte_present) begin
        bytes_r <= bytes_inc;
        if (bytes_inc == '1) begin
          bsat_r <= 1'b1;
        end
        if (!win_full) begin
          fill_r <= fill_r + 1'b1;
        end
      end
      if (in_end_of_file) begin
        flush_r <= 1'b1;
      end
    end
  end

endmodule

/* rtl/core/slc_back.sv */
// Line classifier: consumes window jobs, keeps line counters, holds the result.
module slc_back #(
  parameter int MAX_MARKER_BYTES = slc_pkg::MAX_MARKER_BYTES_DEF,
  parameter int COUNT_WIDTH      = slc_pkg::COUNT_WIDTH_DEF,
  parameter int AVW              = $clog2(MAX_MARKER_BYTES + 1)
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  slc_pkg::cfg_t                        cfg,
  input  logic                                 job_valid,
  input  logic [MAX_MARKER_BYTES*slc_pkg::BYTE_W-1:0] job_window,
  input  logic [AVW-1:0]                       job_avail,
  input  logic                                 job_finish,
  input  logic [COUNT_WIDTH-1:0]               job_bytes,
  input  logic                                 job_bsat,
  output logic                                 job_pop,
  output logic                                 out_empty,
  input  logic                                 out_pop,
  output logic [slc_pkg::OUT_W-1:0]            out_line_total,
  output logic [slc_pkg::OUT_W-1:0]            out_code_total,
  output logic [slc_pkg::OUT_W-1:0]            out_comment_total,
  output logic [slc_pkg::OUT_W-1:0]            out_blank_total,
  output logic [slc_pkg::OUT_W-1:0]            out_byte_total,
  output logic                                 out_saturated
);

  localparam int BW   = slc_pkg::BYTE_W;
  localparam int MB   = slc_pkg::MARKER_BYTES;
  localparam int LW   = slc_pkg::MLEN_W;
  localparam int OW   = slc_pkg::OUT_W;
  localparam int WINW = MAX_MARKER_BYTES * BW;
  localparam int PADW = (WINW > MB * BW) ? WINW : MB * BW;
  localparam int CMPW = (AVW > LW) ? AVW : LW;

  typedef logic [COUNT_WIDTH-1:0] cnt_t;

  // Line state.
  logic          inside_r, inside_nxt;
  logic          atls_r, atls_nxt;
  logic          empty_r, empty_nxt;
  logic          iscom_r, iscom_nxt;
  logic          sls_r, sls_nxt;
  logic [LW-1:0] skip_r, skip_nxt;

  // Counters.
  cnt_t line_r, line_nxt;
  cnt_t code_r, code_nxt;
  cnt_t comm_r, comm_nxt;
  cnt_t blank_r, blank_nxt;
  logic ovf_r, ovf_nxt;

  logic          out_valid_r;
  logic          out_xfer;
  logic          take;
  logic          take_cls;
  logic          take_fin;
  logic [PADW-1:0] win_pad;
  logic [BW-1:0] head;
  logic          is_nl;
  logic          white;
  logic          line_hit;
  logic          open_hit;
  logic          close_hit;
  logic          fin_line;
  logic          bump_line;
  logic          comm_line;

  function automatic logic marker_hit(input logic [PADW-1:0] win,
                                      input logic [AVW-1:0] avail,
                                      input logic [slc_pkg::MARKER_W-1:0] mk,
                                      input logic [LW-1:0] len);
    logic hit;
    hit = (len != '0) && (CMPW'(len) <= CMPW'(avail));
    for (int k = 0; k < MB; k++) begin
      if ((LW'(k) < len) && (win[k*BW +: BW] != mk[k*BW +: BW])) begin
        hit = 1'b0;
      end
    end
    return hit;
  endfunction

  function automatic cnt_t bump(input cnt_t c, input logic en);
    return (en && c != '1) ? c + 1'b1 : c;
  endfunction

  assign out_empty = ~out_valid_r;
  assign out_xfer  = out_pop & out_valid_r;
  assign take      = job_valid & (~job_finish | ~out_valid_r | out_xfer);
  assign take_cls  = take & ~job_finish;
  assign take_fin  = take & job_finish;
  assign job_pop   = take;

  // Marker compares at the window head run in parallel.
  assign win_pad   = PADW'(job_window);
  assign head      = win_pad[BW-1:0];
  assign is_nl     = (head == slc_pkg::CHR_NL);
  assign white     = (head == slc_pkg::CHR_SP) || (head == slc_pkg::CHR_TAB);
  assign line_hit  = marker_hit(win_pad, job_avail, cfg.line_marker, cfg.line_len);
  assign open_hit  = marker_hit(win_pad, job_avail, cfg.open_marker, cfg.open_len);
  assign close_hit = marker_hit(win_pad, job_avail, cfg.close_marker, cfg.close_len);

  // Classification of the byte at the window head.
  always_comb begin
    inside_nxt = inside_r;
    atls_nxt   = atls_r;
    empty_nxt  = empty_r;
    iscom_nxt  = iscom_r;
    sls_nxt    = sls_r;
    skip_nxt   = skip_r;
    fin_line   = take_fin;
    bump_line  = 1'b0;
    if (take_cls) begin
      priority if (skip_r != '0) begin
        skip_nxt = skip_r - 1'b1;
      end else if (sls_r && !is_nl && close_hit) begin
        inside_nxt = 1'b0;
        sls_nxt    = 1'b0;
        skip_nxt   = cfg.close_len - 1'b1;
      end else begin
        if (sls_r && is_nl) begin
          sls_nxt = 1'b0;
        end
        priority if (is_nl) begin
          fin_line  = 1'b1;
          bump_line = 1'b1;
          atls_nxt  = 1'b1;
          empty_nxt = 1'b1;
          iscom_nxt = 1'b0;
        end else if (atls_r && white) begin
        end else if (atls_r && inside_r && close_hit) begin
          atls_nxt   = 1'b0;
          inside_nxt = 1'b0;
          skip_nxt   = cfg.close_len - 1'b1;
          empty_nxt  = 1'b0;
        end else if (atls_r && !inside_r && line_hit) begin
          atls_nxt  = 1'b0;
          iscom_nxt = 1'b1;
        end else if (atls_r && !inside_r && open_hit) begin
          atls_nxt   = 1'b0;
          inside_nxt = 1'b1;
          skip_nxt   = cfg.open_len - 1'b1;
          empty_nxt  = 1'b0;
          sls_nxt    = (cfg.close_len != '0);
        end else begin
          atls_nxt = 1'b0;
          if (!white) begin
            empty_nxt = 1'b0;
          end
        end
      end
    end
  end

  // Saturating counter updates for a finished line.
  always_comb begin
    comm_line = inside_r | iscom_r;
    line_nxt  = bump(line_r, bump_line);
    comm_nxt  = bump(comm_r, fin_line & comm_line);
    blank_nxt = bump(blank_r, fin_line & ~comm_line & empty_r);
    code_nxt  = bump(code_r, fin_line & ~comm_line & ~empty_r);
    ovf_nxt   = ovf_r
              | (bump_line && line_nxt == '1)
              | (fin_line && comm_line && comm_nxt == '1)
              | (fin_line && !comm_line && empty_r && blank_nxt == '1)
              | (fin_line && !comm_line && !empty_r && code_nxt == '1);
  end

  // State registers; a finished file returns them to the start values.
  always_ff @(posedge clk) begin
    if (!rst_n || take_fin) begin
      inside_r <= 1'b0;
      atls_r   <= 1'b1;
      empty_r  <= 1'b1;
      iscom_r  <= 1'b0;
      sls_r    <= 1'b0;
      skip_r   <= '0;
      line_r   <= cnt_t'(1);
      code_r   <= '0;
      comm_r   <= '0;
      blank_r  <= '0;
      ovf_r    <= 1'b0;
    end else begin
      inside_r <= inside_nxt;
      atls_r   <= atls_nxt;
      empty_r  <= empty_nxt;
      iscom_r  <= iscom_nxt;
      sls_r    <= sls_nxt;
      skip_r   <= skip_nxt;
      line_r   <= line_nxt;
      code_r   <= code_nxt;
      comm_r   <= comm_nxt;
      blank_r  <= blank_nxt;
      ovf_r    <= ovf_nxt;
    end
  end

  // Result register and its valid flag.
  always_ff @(posedge clk) begin
    if (take_fin) begin
      out_line_total    <= OW'(line_nxt);
      out_code_total    <= OW'(code_nxt);
      out_comment_total <= OW'(comm_nxt);
      out_blank_total   <= OW'(blank_nxt);
      out_byte_total    <= OW'(job_bytes);
      out_saturated     <= ovf_nxt | job_bsat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take_fin) begin
      out_valid_r <= 1'b1;
    end else if (out_xfer) begin
      out_valid_r <= 1'b0;
    end
  end

endmodule

/* rtl/core/source_line_classifier.sv */
// Source line classifier top level: configuration registers, window, job queue, classifier.
//
// Bytes of a file enter one per cycle while in_full is low. Each byte sits in a window of
// MAX_MARKER_BYTES bytes so that the comment markers are compared against the window head
// in parallel; the classifier behind a short job queue takes one window step per cycle while
// jobs are queued and no waiting result holds an end-of-file job back. An end-of-file item
// drains the window one byte per cycle while the job queue has room and then issues the
// totals, so in_full stays high until the totals are issued. The totals pass through the
// job queue into the result register and stay there until popped. An earlier result that
// is still waiting holds the next file's totals back; the job queue then fills and in_full
// also stays high until that result is popped. The user must write the configuration
// registers only while no file is in flight; the block itself does not enforce this.
module source_line_classifier #(
  parameter int MAX_MARKER_BYTES = slc_pkg::MAX_MARKER_BYTES_DEF,
  parameter int COUNT_WIDTH      = slc_pkg::COUNT_WIDTH_DEF,
  parameter int JOB_QUEUE_DEPTH  = slc_pkg::JOB_QUEUE_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_push,
  output logic                               in_full,
  input  logic [slc_pkg::BYTE_W-1:0]         in_data_byte,
  input  logic                               in_byte_present,
  input  logic                               in_end_of_file,
  output logic                               out_empty,
  input  logic                               out_pop,
  output logic [slc_pkg::OUT_W-1:0]          out_line_total,
  output logic [slc_pkg::OUT_W-1:0]          out_code_total,
  output logic [slc_pkg::OUT_W-1:0]          out_comment_total,
  output logic [slc_pkg::OUT_W-1:0]          out_blank_total,
  output logic [slc_pkg::OUT_W-1:0]          out_byte_total,
  output logic                               out_saturated,
  input  logic                               cfg_write_en,
  input  logic [slc_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [slc_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int AVW  = $clog2(MAX_MARKER_BYTES + 1);
  localparam int WINW = MAX_MARKER_BYTES * slc_pkg::BYTE_W;
  localparam int JW   = WINW + AVW + 1 + COUNT_WIDTH + 1;
  localparam int LW   = slc_pkg::MLEN_W;

  slc_pkg::cfg_t cfg_r;

  logic                   fr_push;
  logic                   q_full;
  logic [WINW-1:0]        fr_window;
  logic [AVW-1:0]         fr_avail;
  logic                   fr_finish;
  logic [COUNT_WIDTH-1:0] fr_bytes;
  logic                   fr_bsat;
  logic [JW-1:0]          q_in;
  logic [JW-1:0]          q_out;
  logic                   q_empty;
  logic                   bk_pop;
  logic [WINW-1:0]        bk_window;
  logic [AVW-1:0]         bk_avail;
  logic                   bk_finish;
  logic [COUNT_WIDTH-1:0] bk_bytes;
  logic                   bk_bsat;

  // Configuration registers; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        slc_pkg::REG_LINE_MARKER:      cfg_r.line_marker  <= cfg_data;
        slc_pkg::REG_LINE_MARKER_LEN:  cfg_r.line_len     <= cfg_data[LW-1:0];
        slc_pkg::REG_OPEN_MARKER:      cfg_r.open_marker  <= cfg_data;
        slc_pkg::REG_OPEN_MARKER_LEN:  cfg_r.open_len     <= cfg_data[LW-1:0];
        slc_pkg::REG_CLOSE_MARKER:     cfg_r.close_marker <= cfg_data;
        slc_pkg::REG_CLOSE_MARKER_LEN: cfg_r.close_len    <= cfg_data[LW-1:0];
        default: begin
        end
      endcase
    end
  end

  slc_front #(
    .MAX_MARKER_BYTES(MAX_MARKER_BYTES),
    .COUNT_WIDTH     (COUNT_WIDTH),
    .AVW             (AVW)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_data_byte   (in_data_byte),
    .in_byte_present(in_byte_present),
    .in_end_of_file (in_end_of_file),
    .job_push       (fr_push),
    .job_full       (q_full),
    .job_window     (fr_window),
    .job_avail      (fr_avail),
    .job_finish     (fr_finish),
    .job_bytes      (fr_bytes),
    .job_bsat       (fr_bsat)
  );

  // Jobs travel through the queue as one packed word.
  assign q_in = {fr_window, fr_avail, fr_finish, fr_bytes, fr_bsat};
  assign {bk_window, bk_avail, bk_finish, bk_bytes, bk_bsat} = q_out;

  slc_fifo #(
    .WIDTH(JW),
    .DEPTH(JOB_QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (fr_push),
    .push_data(q_in),
    .full     (q_full),
    .pop      (bk_pop),
    .empty    (q_empty),
    .pop_data (q_out)
  );

  slc_back #(
    .MAX_MARKER_BYTES(MAX_MARKER_BYTES),
    .COUNT_WIDTH     (COUNT_WIDTH),
    .AVW             (AVW)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .job_valid        (~q_empty),
    .job_window       (bk_window),
    .job_avail        (bk_avail),
    .job_finish       (bk_finish),
    .job_bytes        (bk_bytes),
    .job_bsat         (bk_bsat),
    .job_pop          (bk_pop),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_line_total   (out_line_total),
    .out_code_total   (out_code_total),
    .out_comment_total(out_comment_total),
    .out_blank_total  (out_blank_total),
    .out_byte_total   (out_byte_total),
    .out_saturated    (out_saturated)
  );

endmodule
